### rtl/core/snf_pkg.sv
// shared constants for the scan object narrowest finder
package snf_pkg;

    // default field widths of a sample
    localparam int DEFAULT_RANGE_BITS = 10;
    localparam int DEFAULT_ANGLE_BITS = 8;

    // threshold register
    localparam int          THRESH_W     = 10;
    localparam logic [9:0]  THRESH_RESET = 10'd80;

    // result field widths
    localparam int NUMBER_W = 8;
    localparam int WIDTH_W  = 20;
    localparam int SUM_O_W  = 11;
    localparam int SPAN_O_W = 8;
    localparam int CENTER_W = 9;
    localparam int OUT_W    = NUMBER_W + WIDTH_W + SUM_O_W + SPAN_O_W + CENTER_W;

    // saturation limits
    localparam logic [NUMBER_W-1:0] COUNT_MAX = 8'd255;
    localparam logic [WIDTH_W-1:0]  WIDTH_MAX = 20'hFFFFF;

    // fixed point width coefficient, about 256*pi/360 scaled by 1024
    localparam int COEF_W = 12;

endpackage

### rtl/core/scan_object_narrowest_finder.sv
// top level of the scan object narrowest finder
//
// Usage: one range sample per scan angle enters on the s_ stream
// (s_tdata = scan_angle, range_cm from the lowest bit; s_tlast = scan_end).
// An object opens when the range drops below the threshold and closes
// when it rises above it; the narrowest object of the sweep is reported
// once on the m_ stream after the transaction that carries s_tlast.
// The threshold is written on the cfg_ channel (cfg_ready is always high);
// the user writes it only while the block is idle; no logic enforces this.
// A sample that closes no object is taken directly. A sample that
// closes an object of nonzero span holds s_tready low while the width
// product runs through a bit-serial shift-add multiplier, one bit of the
// distance sum per cycle, and then through a compare state.
// The last sample of a sweep adds a load state for the result register.
// The result sits in an output register; s_tready stays high while it waits
// for m_tready, but the next sweep end holds until that result is taken.
// Reset clears the sweep state, the output valid, and sets the threshold to 80.
module scan_object_narrowest_finder #(
    parameter int RANGE_BITS = snf_pkg::DEFAULT_RANGE_BITS,
    parameter int ANGLE_BITS = snf_pkg::DEFAULT_ANGLE_BITS
) (
    input  logic                                              clk,
    input  logic                                              rst_n,
    // sample stream
    input  logic                                              s_tvalid,
    output logic                                              s_tready,
    // fields from bit 0: scan_angle, range_cm, zero padding
    input  logic [((ANGLE_BITS+RANGE_BITS+7)/8)*8-1:0]        s_tdata,
    // scan_end
    input  logic                                              s_tlast,
    // result stream
    output logic                                              m_tvalid,
    input  logic                                              m_tready,
    // fields from bit 0: best_number, best_width_q8, best_dist_sum,
    // best_span, best_center_half
    output logic [snf_pkg::OUT_W-1:0]                         m_tdata,
    // found
    output logic                                              m_tuser,
    // threshold write channel
    input  logic                                              cfg_valid,
    output logic                                              cfg_ready,
    input  logic [snf_pkg::THRESH_W-1:0]                      cfg_data
);
    import snf_pkg::*;

    localparam int IN_W  = ANGLE_BITS + RANGE_BITS;
    localparam int SUM_W = RANGE_BITS + 1;
    localparam int M_W   = ANGLE_BITS + COEF_W;
    localparam int ACC_W = SUM_W + M_W;
    localparam int EXT_W = (ACC_W > 31) ? ACC_W : 31;
    localparam int CNT_W = $clog2(SUM_W);
    localparam int CMP_W = (RANGE_BITS > THRESH_W) ? RANGE_BITS : THRESH_W;

    typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_CMP, ST_FIN} state_t;

    state_t                 state_reg, state_next;
    logic [THRESH_W-1:0]    thresh_reg, thresh_next;
    logic                   inside_reg, inside_next;
    logic [ANGLE_BITS-1:0]  open_angle_reg, open_angle_next;
    logic [RANGE_BITS-1:0]  open_range_reg, open_range_next;
    logic [ANGLE_BITS-1:0]  prior_angle_reg, prior_angle_next;
    logic [RANGE_BITS-1:0]  prior_range_reg, prior_range_next;
    logic [NUMBER_W-1:0]    count_reg, count_next;
    logic                   have_best_reg, have_best_next;
    logic [WIDTH_W-1:0]     best_width_reg, best_width_next;
    logic [NUMBER_W-1:0]    best_number_reg, best_number_next;
    logic [SUM_W-1:0]       best_sum_reg, best_sum_next;
    logic [ANGLE_BITS-1:0]  best_span_reg, best_span_next;
    logic [CENTER_W-1:0]    best_center_reg, best_center_next;
    logic                   last_reg, last_next;
    logic [SUM_W-1:0]       cand_sum_reg, cand_sum_next;
    logic [ANGLE_BITS-1:0]  cand_span_reg, cand_span_next;
    logic [CENTER_W-1:0]    cand_center_reg, cand_center_next;
    logic [SUM_W-1:0]       mul_sum_reg, mul_sum_next;
    logic [ACC_W-1:0]       mul_m_reg, mul_m_next;
    logic [ACC_W-1:0]       acc_reg, acc_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   m_valid_reg, m_valid_next;
    logic [OUT_W-1:0]       m_data_reg, m_data_next;
    logic                   m_user_reg, m_user_next;

    // sample fields
    logic [ANGLE_BITS-1:0]  in_angle;
    logic [RANGE_BITS-1:0]  in_range;
    logic                   open_hit;
    logic                   close_hit;
    logic [ANGLE_BITS-1:0]  span_now;
    logic [SUM_W-1:0]       sum_now;
    logic [CENTER_W-1:0]    center_now;
    logic [M_W-1:0]         m_now;
    logic [EXT_W-1:0]       acc_ext;
    logic [WIDTH_W-1:0]     width_sat;
    logic [NUMBER_W-1:0]    count_inc;

    assign in_angle = s_tdata[ANGLE_BITS-1:0];
    assign in_range = s_tdata[IN_W-1:ANGLE_BITS];

    // object open and close tests against the threshold
    assign open_hit  = !inside_reg && (CMP_W'(in_range) < CMP_W'(thresh_reg));
    assign close_hit = inside_reg && (CMP_W'(in_range) > CMP_W'(thresh_reg));

    // closing object figures, end is the prior sample
    assign span_now   = prior_angle_reg - open_angle_reg;
    assign sum_now    = SUM_W'(open_range_reg) + SUM_W'(prior_range_reg);
    assign center_now = CENTER_W'({prior_angle_reg, 1'b0} - (ANGLE_BITS+1)'(span_now));
    // span * 2288 as shifts: 2048 + 256 - 16
    assign m_now      = M_W'({span_now, 11'b0}) + M_W'({span_now, 8'b0})
                      - M_W'({span_now, 4'b0});

    // width scaling and saturation
    assign acc_ext   = EXT_W'(acc_reg);
    assign width_sat = (|acc_ext[EXT_W-1:30]) ? WIDTH_MAX : acc_ext[29:10];
    assign count_inc = (count_reg == COUNT_MAX) ? COUNT_MAX : count_reg + 1'b1;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign m_tuser   = m_user_reg;

    // next state and datapath
    always_comb
    begin
        state_next       = state_reg;
        thresh_next      = thresh_reg;
        inside_next      = inside_reg;
        open_angle_next  = open_angle_reg;
        open_range_next  = open_range_reg;
        prior_angle_next = prior_angle_reg;
        prior_range_next = prior_range_reg;
        count_next       = count_reg;
        have_best_next   = have_best_reg;
        best_width_next  = best_width_reg;
        best_number_next = best_number_reg;
        best_sum_next    = best_sum_reg;
        best_span_next   = best_span_reg;
        best_center_next = best_center_reg;
        last_next        = last_reg;
        cand_sum_next    = cand_sum_reg;
        cand_span_next   = cand_span_reg;
        cand_center_next = cand_center_reg;
        mul_sum_next     = mul_sum_reg;
        mul_m_next       = mul_m_reg;
        acc_next         = acc_reg;
        cnt_next         = cnt_reg;
        m_valid_next     = m_valid_reg;
        m_data_next      = m_data_reg;
        m_user_next      = m_user_reg;

        // config write transaction
        if (cfg_valid)
        begin
            thresh_next = cfg_data;
        end

        // result transaction taken
        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    last_next = s_tlast;
                    state_next = s_tlast ? ST_FIN : ST_IDLE;
                    if (open_hit)
                    begin
                        open_angle_next = in_angle;
                        open_range_next = in_range;
                        inside_next     = 1'b1;
                    end
                    else if (close_hit)
                    begin
                        inside_next = 1'b0;
                        if (span_now != '0)
                        begin
                            cand_sum_next    = sum_now;
                            cand_span_next   = span_now;
                            cand_center_next = center_now;
                            mul_sum_next     = sum_now;
                            mul_m_next       = ACC_W'(m_now);
                            acc_next         = '0;
                            cnt_next         = '0;
                            state_next       = ST_MUL;
                        end
                    end
                    prior_angle_next = in_angle;
                    prior_range_next = in_range;
                end
            end

            ST_MUL:
            begin
                // one bit of the distance sum per cycle
                if (mul_sum_reg[0])
                begin
                    acc_next = acc_reg + mul_m_reg;
                end
                mul_m_next   = {mul_m_reg[ACC_W-2:0], 1'b0};
                mul_sum_next = {1'b0, mul_sum_reg[SUM_W-1:1]};
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(SUM_W - 1))
                begin
                    state_next = ST_CMP;
                end
            end

            ST_CMP:
            begin
                count_next = count_inc;
                // first strictly narrower object wins
                if (!have_best_reg || (width_sat < best_width_reg))
                begin
                    have_best_next   = 1'b1;
                    best_width_next  = width_sat;
                    best_number_next = count_inc;
                    best_sum_next    = cand_sum_reg;
                    best_span_next   = cand_span_reg;
                    best_center_next = cand_center_reg;
                end
                state_next = last_reg ? ST_FIN : ST_IDLE;
            end

            ST_FIN:
            begin
                // load result once the output register is free
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_user_next  = have_best_reg;
                    if (have_best_reg)
                    begin
                        m_data_next = {best_center_reg, SPAN_O_W'(best_span_reg),
                                       SUM_O_W'(best_sum_reg), best_width_reg,
                                       best_number_reg};
                    end
                    else
                    begin
                        m_data_next = '0;
                    end
                    inside_next      = 1'b0;
                    open_angle_next  = '0;
                    open_range_next  = '0;
                    prior_angle_next = '0;
                    prior_range_next = '0;
                    count_next       = '0;
                    have_best_next   = 1'b0;
                    best_width_next  = '0;
                    best_number_next = '0;
                    best_sum_next    = '0;
                    best_span_next   = '0;
                    best_center_next = '0;
                    state_next       = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            thresh_reg      <= THRESH_RESET;
            inside_reg      <= 1'b0;
            open_angle_reg  <= '0;
            open_range_reg  <= '0;
            prior_angle_reg <= '0;
            prior_range_reg <= '0;
            count_reg       <= '0;
            have_best_reg   <= 1'b0;
            best_width_reg  <= '0;
            best_number_reg <= '0;
            best_sum_reg    <= '0;
            best_span_reg   <= '0;
            best_center_reg <= '0;
            last_reg        <= 1'b0;
            cand_sum_reg    <= '0;
            cand_span_reg   <= '0;
            cand_center_reg <= '0;
            mul_sum_reg     <= '0;
            mul_m_reg       <= '0;
            acc_reg         <= '0;
            cnt_reg         <= '0;
            m_valid_reg     <= 1'b0;
            m_data_reg      <= '0;
            m_user_reg      <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            thresh_reg      <= thresh_next;
            inside_reg      <= inside_next;
            open_angle_reg  <= open_angle_next;
            open_range_reg  <= open_range_next;
            prior_angle_reg <= prior_angle_next;
            prior_range_reg <= prior_range_next;
            count_reg       <= count_next;
            have_best_reg   <= have_best_next;
            best_width_reg  <= best_width_next;
            best_number_reg <= best_number_next;
            best_sum_reg    <= best_sum_next;
            best_span_reg   <= best_span_next;
            best_center_reg <= best_center_next;
            last_reg        <= last_next;
            cand_sum_reg    <= cand_sum_next;
            cand_span_reg   <= cand_span_next;
            cand_center_reg <= cand_center_next;
            mul_sum_reg     <= mul_sum_next;
            mul_m_reg       <= mul_m_next;
            acc_reg         <= acc_next;
            cnt_reg         <= cnt_next;
            m_valid_reg     <= m_valid_next;
            m_data_reg      <= m_data_next;
            m_user_reg      <= m_user_next;
        end
    end

endmodule

### rtl/core/snf_checker.sv
// port level checker for the scan object narrowest finder, with its bind
module snf_checker #(
    parameter int RANGE_BITS = snf_pkg::DEFAULT_RANGE_BITS,
    parameter int ANGLE_BITS = snf_pkg::DEFAULT_ANGLE_BITS
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       s_tvalid,
    input  logic                                       s_tready,
    input  logic [((ANGLE_BITS+RANGE_BITS+7)/8)*8-1:0] s_tdata,
    input  logic                                       s_tlast,
    input  logic                                       m_tvalid,
    input  logic                                       m_tready,
    input  logic [snf_pkg::OUT_W-1:0]                  m_tdata,
    input  logic                                       m_tuser
);
    import snf_pkg::*;

    // a stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // a stalled sample holds
    a_sample_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tlast))
        else $error("sample changed while stalled");

    // no object means an all zero result
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("empty sweep result not zero");

    // a found object has a nonzero number and span
    a_found_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> (m_tdata[NUMBER_W-1:0] != '0)
            && (m_tdata[OUT_W-CENTER_W-1:OUT_W-CENTER_W-SPAN_O_W] != '0))
        else $error("found result with zero number or span");

    // the sample side only stalls after taking a sample
    a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_tready) |-> $past(s_tvalid))
        else $error("s_tready dropped without a sample transaction");

endmodule

bind scan_object_narrowest_finder snf_checker #(
    .RANGE_BITS(RANGE_BITS),
    .ANGLE_BITS(ANGLE_BITS)
) u_snf_checker (.*);
